// ===== sv/rcrx_pkg.sv =====
// Package for the RC receiver: shared constants, decode types and register map.
package rcrx_pkg;

    localparam int PACKET_BYTES_DEF = 19;
    localparam int HOP_CHANNELS     = 4;
    localparam int HOP_IDX_W        = 2;
    localparam int CHAN_W           = 7;

    // Bytes the decoder looks at: header, hop bytes, sticks and aux bytes.
    localparam int DECODE_BYTES = 18;
    localparam int DIFF_W       = 18;

    localparam logic [7:0] BIND_MARK = 8'hAA;
    localparam logic [7:0] DATA_MARK = 8'h55;

    localparam logic [7:0] LO_NIBBLE    = 8'h0F;
    localparam logic [6:0] HOP0_OFFSET  = 7'h03;
    localparam logic [6:0] HOP1_OFFSET  = 7'h16;
    localparam logic [6:0] HOP2_OFFSET  = 7'h2D;
    localparam logic [7:0] ARM_MASK     = 8'h10;
    localparam logic [7:0] RATES_MASK   = 8'h01;

    localparam logic signed [DIFF_W-1:0] STICK_CENTER    = 18'sd1500;
    localparam logic signed [DIFF_W-1:0] THROTTLE_OFFSET = 18'sd1000;
    localparam logic signed [DIFF_W-1:0] STICK_MIN       = -18'sd1024;
    localparam logic signed [DIFF_W-1:0] STICK_MAX       = 18'sd1023;
    localparam logic signed [DIFF_W-1:0] THROTTLE_MAX    = 18'sd2047;

    localparam logic [31:0] FAILSAFE_TIMEOUT_RST = 32'd1000000;
    localparam logic [31:0] HOP_TIMEOUT_RST      = 32'd20000;

    // Register index as seen in paddr[2]
    localparam logic REG_FAILSAFE_TIMEOUT = 1'b0;
    localparam logic REG_HOP_TIMEOUT      = 1'b1;

    localparam logic ACTION_POLL = 1'b0;
    localparam logic ACTION_BYTE = 1'b1;

    typedef logic [DECODE_BYTES-1:0][7:0] t_dec_bytes;
    typedef logic [HOP_CHANNELS-1:0][CHAN_W-1:0] t_hop_tbl;

    typedef struct packed {
        logic                is_bind;
        logic                is_data;
        t_hop_tbl            hop_tbl;
        logic signed [10:0]  roll;
        logic signed [10:0]  pitch;
        logic signed [10:0]  yaw;
        logic signed [11:0]  throttle;
        logic [1:0]          aux;
    } t_decode;

endpackage

// ===== sv/rcrx_packet_decode.sv =====
// Packet decoder: header checks, hop table from a bind packet, saturated sticks and aux bits.
module rcrx_packet_decode (
    input  rcrx_pkg::t_dec_bytes i_bytes,
    output rcrx_pkg::t_decode    o_dec
);

    logic [15:0] w_roll, w_pitch, w_throttle, w_yaw;
    logic signed [rcrx_pkg::DIFF_W-1:0] s_roll, s_pitch, s_throttle, s_yaw;

    // Little-endian stick words
    assign w_roll     = {i_bytes[10], i_bytes[9]};
    assign w_pitch    = {i_bytes[12], i_bytes[11]};
    assign w_throttle = {i_bytes[14], i_bytes[13]};
    assign w_yaw      = {i_bytes[16], i_bytes[15]};

    // Roll and pitch are negated around center
    assign s_roll     = rcrx_pkg::STICK_CENTER - $signed({2'b00, w_roll});
    assign s_pitch    = rcrx_pkg::STICK_CENTER - $signed({2'b00, w_pitch});
    assign s_yaw      = $signed({2'b00, w_yaw}) - rcrx_pkg::STICK_CENTER;
    assign s_throttle = $signed({2'b00, w_throttle}) - rcrx_pkg::THROTTLE_OFFSET;

    always_comb begin
        o_dec.is_bind = (i_bytes[0] == rcrx_pkg::BIND_MARK);
        o_dec.is_data = (i_bytes[0] == rcrx_pkg::DATA_MARK);

        o_dec.hop_tbl[0] = (i_bytes[1][6:0] & rcrx_pkg::LO_NIBBLE[6:0]) + rcrx_pkg::HOP0_OFFSET;
        o_dec.hop_tbl[1] = {3'b000, i_bytes[1][7:4]} + rcrx_pkg::HOP1_OFFSET;
        o_dec.hop_tbl[2] = (i_bytes[2][6:0] & rcrx_pkg::LO_NIBBLE[6:0]) + rcrx_pkg::HOP2_OFFSET;
        o_dec.hop_tbl[3] = {3'b000, i_bytes[2][7:4]};

        if (s_roll < rcrx_pkg::STICK_MIN) begin
            o_dec.roll = rcrx_pkg::STICK_MIN[10:0];
        end else if (s_roll > rcrx_pkg::STICK_MAX) begin
            o_dec.roll = rcrx_pkg::STICK_MAX[10:0];
        end else begin
            o_dec.roll = s_roll[10:0];
        end

        if (s_pitch < rcrx_pkg::STICK_MIN) begin
            o_dec.pitch = rcrx_pkg::STICK_MIN[10:0];
        end else if (s_pitch > rcrx_pkg::STICK_MAX) begin
            o_dec.pitch = rcrx_pkg::STICK_MAX[10:0];
        end else begin
            o_dec.pitch = s_pitch[10:0];
        end

        if (s_yaw < rcrx_pkg::STICK_MIN) begin
            o_dec.yaw = rcrx_pkg::STICK_MIN[10:0];
        end else if (s_yaw > rcrx_pkg::STICK_MAX) begin
            o_dec.yaw = rcrx_pkg::STICK_MAX[10:0];
        end else begin
            o_dec.yaw = s_yaw[10:0];
        end

        if (s_throttle < rcrx_pkg::STICK_MIN) begin
            o_dec.throttle = rcrx_pkg::STICK_MIN[11:0];
        end else if (s_throttle > rcrx_pkg::THROTTLE_MAX) begin
            o_dec.throttle = rcrx_pkg::THROTTLE_MAX[11:0];
        end else begin
            o_dec.throttle = s_throttle[11:0];
        end

        o_dec.aux[0] = |(i_bytes[16] & rcrx_pkg::ARM_MASK);
        o_dec.aux[1] = |(i_bytes[17] & rcrx_pkg::RATES_MASK);
    end

endmodule

// ===== sv/rc_receiver_bind_hop_failsafe_core.sv =====
// Top level of the RC receiver: byte collection, bind, hopping, failsafe and result register.
//
// One input word (payload byte or time poll, with its microsecond stamp) can be taken every
// cycle unless a result is held up, and its result word appears on the master side in the
// cycle after acceptance. The whole state update of a word (byte store, packet decode, hop
// and failsafe timers) is combinational. There is one result register: while a result waits
// to be taken, s_axis_tready stays low, and a new word enters in the same cycle the pending
// result is taken, so words flow back to back while the master side keeps m_axis_tready
// high. The two timeout registers sit at byte addresses 0 (failsafe) and 4 (hop).
module rc_receiver_bind_hop_failsafe_core #(
    parameter int PACKET_BYTES = rcrx_pkg::PACKET_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] payload_byte, [39:8] now_us
    input  logic [39:0] s_axis_tdata,
    // [0] action
    input  logic        s_axis_tuser,
    input  logic        s_axis_tlast,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [10:0] roll_cmd, [21:11] pitch_cmd, [32:22] yaw_cmd, [44:33] throttle_cmd,
    // [45] aux_arm, [46] aux_rates, [48:47] aux_changed, [49] failsafe_active,
    // [50] bound, [57:51] rf_channel, [58] packet_valid, [63:59] zero
    output logic [63:0] m_axis_tdata,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = $clog2(PACKET_BYTES);
    localparam int CNT_W = $clog2(PACKET_BYTES + 1);

    logic [31:0] r_fs_timeout, r_hop_timeout;

    logic                              r_bound, n_bound;
    logic [PACKET_BYTES-1:0][7:0]      r_pkt, n_pkt;
    logic [CNT_W-1:0]                  r_idx, n_idx;
    rcrx_pkg::t_hop_tbl                r_hop_tbl, n_hop_tbl;
    logic [rcrx_pkg::HOP_IDX_W-1:0]    r_hop_idx, n_hop_idx;
    logic [31:0]                       r_lpt, n_lpt;
    logic [31:0]                       r_lvt, n_lvt;
    logic signed [10:0]                r_roll, n_roll, r_pitch, n_pitch, r_yaw, n_yaw;
    logic signed [11:0]                r_thr, n_thr;
    logic [1:0]                        r_aux, n_aux;
    logic [1:0]                        r_prev_aux, n_prev_aux;
    logic                              r_fs, n_fs;

    logic        r_out_valid;
    logic [63:0] r_out_data, n_out_data;

    logic        in_accept;
    logic        in_action, in_last;
    logic [7:0]  in_byte;
    logic [31:0] in_now;
    logic [1:0]  changed;
    logic        valid;

    rcrx_pkg::t_dec_bytes dec_bytes;
    rcrx_pkg::t_decode    dec;

    assign in_action = s_axis_tuser;
    assign in_last   = s_axis_tlast;
    assign in_byte   = s_axis_tdata[7:0];
    assign in_now    = s_axis_tdata[39:8];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Config port
    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[2])
            rcrx_pkg::REG_FAILSAFE_TIMEOUT: prdata = r_fs_timeout;
            rcrx_pkg::REG_HOP_TIMEOUT:      prdata = r_hop_timeout;
            default:                        prdata = r_fs_timeout;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs_timeout  <= rcrx_pkg::FAILSAFE_TIMEOUT_RST;
            r_hop_timeout <= rcrx_pkg::HOP_TIMEOUT_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                rcrx_pkg::REG_FAILSAFE_TIMEOUT: r_fs_timeout  <= pwdata;
                rcrx_pkg::REG_HOP_TIMEOUT:      r_hop_timeout <= pwdata;
                default:                        r_fs_timeout  <= r_fs_timeout;
            endcase
        end
    end

    // Decoder sees the packet with the current word already stored
    always_comb begin
        for (int k = 0; k < rcrx_pkg::DECODE_BYTES; k++) begin
            if (in_action == rcrx_pkg::ACTION_BYTE && r_idx == CNT_W'(k)) begin
                dec_bytes[k] = in_byte;
            end else begin
                dec_bytes[k] = r_pkt[k];
            end
        end
    end

    rcrx_packet_decode u_decode (
        .i_bytes (dec_bytes),
        .o_dec   (dec)
    );

    always_comb begin
        n_bound    = r_bound;
        n_pkt      = r_pkt;
        n_idx      = r_idx;
        n_hop_tbl  = r_hop_tbl;
        n_hop_idx  = r_hop_idx;
        n_lpt      = r_lpt;
        n_lvt      = r_lvt;
        n_roll     = r_roll;
        n_pitch    = r_pitch;
        n_yaw      = r_yaw;
        n_thr      = r_thr;
        n_aux      = r_aux;
        n_prev_aux = r_prev_aux;
        n_fs       = r_fs;
        changed    = 2'b00;
        valid      = 1'b0;

        if (in_action == rcrx_pkg::ACTION_BYTE) begin
            // Drop bytes past the end of the buffer
            if (r_idx < CNT_W'(PACKET_BYTES)) begin
                n_pkt[r_idx[IDX_W-1:0]] = in_byte;
                n_idx = r_idx + CNT_W'(1);
            end
            if (in_last) begin
                n_idx = '0;
                if (!r_bound) begin
                    if (dec.is_bind) begin
                        n_hop_tbl = dec.hop_tbl;
                        n_bound   = 1'b1;
                        n_hop_idx = n_hop_idx + rcrx_pkg::HOP_IDX_W'(1);
                        valid     = 1'b1;
                    end
                end else begin
                    n_lpt = in_now;
                    if (dec.is_data) begin
                        n_roll     = dec.roll;
                        n_pitch    = dec.pitch;
                        n_yaw      = dec.yaw;
                        n_thr      = dec.throttle;
                        n_aux      = dec.aux;
                        changed    = dec.aux ^ r_prev_aux;
                        n_prev_aux = dec.aux;
                        n_lvt      = in_now;
                        n_fs       = 1'b0;
                        n_hop_idx  = n_hop_idx + rcrx_pkg::HOP_IDX_W'(1);
                        valid      = 1'b1;
                    end
                end
            end
        end

        // Silence hop; a fresh bind still sees the old packet stamp
        if (n_bound && ((in_now - n_lpt) > r_hop_timeout)) begin
            n_lpt     = in_now;
            n_hop_idx = n_hop_idx + rcrx_pkg::HOP_IDX_W'(1);
        end

        if ((in_now - n_lvt) > r_fs_timeout) begin
            n_fs    = 1'b1;
            n_roll  = '0;
            n_pitch = '0;
            n_yaw   = '0;
            n_thr   = '0;
        end

        n_out_data = {5'b00000, valid, n_hop_tbl[n_hop_idx], n_bound, n_fs, changed,
                      n_aux[1], n_aux[0], n_thr, n_yaw, n_pitch, n_roll};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound    <= 1'b0;
            r_pkt      <= '0;
            r_idx      <= '0;
            r_hop_tbl  <= '0;
            r_hop_idx  <= '0;
            r_lpt      <= '0;
            r_lvt      <= '0;
            r_roll     <= '0;
            r_pitch    <= '0;
            r_yaw      <= '0;
            r_thr      <= '0;
            r_aux      <= '0;
            r_prev_aux <= '0;
            r_fs       <= 1'b0;
        end else if (in_accept) begin
            r_bound    <= n_bound;
            r_pkt      <= n_pkt;
            r_idx      <= n_idx;
            r_hop_tbl  <= n_hop_tbl;
            r_hop_idx  <= n_hop_idx;
            r_lpt      <= n_lpt;
            r_lvt      <= n_lvt;
            r_roll     <= n_roll;
            r_pitch    <= n_pitch;
            r_yaw      <= n_yaw;
            r_thr      <= n_thr;
            r_aux      <= n_aux;
            r_prev_aux <= n_prev_aux;
            r_fs       <= n_fs;
        end
    end

    // Result register: load on accept, drain when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

// ===== bench/rc_receiver_bind_hop_failsafe_core_tb.sv =====
// Testbench for the RC receiver core: bind, hop and failsafe behavior checked word by word.
`timescale 1ns / 100ps

module rc_receiver_bind_hop_failsafe_core_tb;

    localparam int PKT_LEN     = rcrx_pkg::PACKET_BYTES_DEF;
    localparam int CENTER_US   = 1500;
    localparam int THR_ZERO_US = 1000;
    localparam int CMD_MIN     = -1024;
    localparam int CMD_MAX     = 1023;
    localparam int THR_MAX     = 2047;
    localparam int CYCLE_LIMIT = 400000;

    // Result word fields, packet_valid in the top bit down to roll in the low bits
    typedef struct packed {
        logic        packet_valid;
        logic [6:0]  rf_channel;
        logic        bound;
        logic        failsafe;
        logic [1:0]  aux_changed;
        logic        aux_rates;
        logic        aux_arm;
        logic [11:0] throttle;
        logic [10:0] yaw;
        logic [10:0] pitch;
        logic [10:0] roll;
    } t_rc_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        s_axis_tuser = rcrx_pkg::ACTION_POLL;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    rc_receiver_bind_hop_failsafe_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #4 i_clk = ~i_clk;

    // Receiver state as predicted
    logic        rx_bound = 1'b0;
    logic [7:0]  rx_bytes [PKT_LEN] = '{default: 8'h00};
    int          rx_fill = 0;
    logic [6:0]  hop_chan [rcrx_pkg::HOP_CHANNELS] = '{default: 7'h00};
    logic [1:0]  hop_sel = '0;
    logic [31:0] last_rx_us = '0;
    logic [31:0] last_valid_us = '0;
    int          stick [4] = '{default: 0};
    logic [1:0]  aux_state = '0;
    logic [1:0]  prev_aux = '0;
    logic        in_failsafe = 1'b0;
    logic [31:0] cfg_failsafe_us = rcrx_pkg::FAILSAFE_TIMEOUT_RST;
    logic [31:0] cfg_hop_us = rcrx_pkg::HOP_TIMEOUT_RST;

    t_rc_result  rc_expected [$];
    int          mismatch_count = 0;
    int          items_sent = 0;
    int          cycle_count = 0;
    logic [31:0] stamp_us = '0;
    int          src_run_left = 0;
    bit          src_no_gaps = 1'b0;
    int          sink_hold_cycles = 0;

    function automatic int clamp(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int stick_word(input int pos);
        return int'(rx_bytes[pos]) + 256 * int'(rx_bytes[pos + 1]);
    endfunction

    // Advance the predicted receiver by one word and form its result
    function automatic t_rc_result step_receiver(input logic act, input logic [7:0] b,
                                                 input logic lst, input logic [31:0] now);
        t_rc_result r;
        logic [1:0] aux_now;
        r = '0;
        if (act == rcrx_pkg::ACTION_BYTE) begin
            if (rx_fill < PKT_LEN) begin
                rx_bytes[rx_fill] = b;
                rx_fill++;
            end
            if (lst) begin
                rx_fill = 0;
                if (!rx_bound) begin
                    if (rx_bytes[0] == rcrx_pkg::BIND_MARK) begin
                        hop_chan[0] = 7'(rx_bytes[1] & rcrx_pkg::LO_NIBBLE)
                                      + rcrx_pkg::HOP0_OFFSET;
                        hop_chan[1] = 7'(rx_bytes[1] >> 4) + rcrx_pkg::HOP1_OFFSET;
                        hop_chan[2] = 7'(rx_bytes[2] & rcrx_pkg::LO_NIBBLE)
                                      + rcrx_pkg::HOP2_OFFSET;
                        hop_chan[3] = 7'(rx_bytes[2] >> 4);
                        rx_bound = 1'b1;
                        hop_sel++;
                        r.packet_valid = 1'b1;
                    end
                end else begin
                    last_rx_us = now;
                    if (rx_bytes[0] == rcrx_pkg::DATA_MARK) begin
                        stick[0] = clamp(CENTER_US - stick_word(9), CMD_MIN, CMD_MAX);
                        stick[1] = clamp(CENTER_US - stick_word(11), CMD_MIN, CMD_MAX);
                        stick[2] = clamp(stick_word(15) - CENTER_US, CMD_MIN, CMD_MAX);
                        stick[3] = clamp(stick_word(13) - THR_ZERO_US, CMD_MIN, THR_MAX);
                        aux_now = {(rx_bytes[17] & rcrx_pkg::RATES_MASK) != 0,
                                   (rx_bytes[16] & rcrx_pkg::ARM_MASK) != 0};
                        aux_state = aux_now;
                        r.aux_changed = aux_now ^ prev_aux;
                        prev_aux = aux_now;
                        last_valid_us = now;
                        in_failsafe = 1'b0;
                        hop_sel++;
                        r.packet_valid = 1'b1;
                    end
                end
            end
        end
        if (rx_bound && (now - last_rx_us) > cfg_hop_us) begin
            last_rx_us = now;
            hop_sel++;
        end
        if ((now - last_valid_us) > cfg_failsafe_us) begin
            in_failsafe = 1'b1;
            stick = '{default: 0};
        end
        r.roll = 11'(stick[0]);
        r.pitch = 11'(stick[1]);
        r.yaw = 11'(stick[2]);
        r.throttle = 12'(stick[3]);
        r.aux_arm = aux_state[0];
        r.aux_rates = aux_state[1];
        r.failsafe = in_failsafe;
        r.bound = rx_bound;
        r.rf_channel = hop_chan[hop_sel];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [11:0] got,
                               input logic [11:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // Mostly short random waits, with occasional runs of back-to-back words
    function automatic int draw_wait(inout int run_left);
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            run_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    task automatic tick_stamp();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) stamp_us += $urandom_range(0, 400);
        else if (pick < 90) stamp_us += $urandom_range(0, 5000);
        else if (pick < 98) stamp_us += $urandom_range(15000, 30000);
        else stamp_us += $urandom_range(900000, 1300000);
    endtask

    task automatic send_word(input logic act, input logic [7:0] b, input logic lst,
                             input logic [31:0] now);
        int gap;
        gap = src_no_gaps ? 0 : draw_wait(src_run_left);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {now, b};
        s_axis_tuser <= act;
        s_axis_tlast <= lst;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        rc_expected.push_back(step_receiver(act, b, lst, now));
        items_sent++;
    endtask

    // Drop valid and hold until every result is back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (rc_expected.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic check_reg(input logic sel);
        logic [31:0] want;
        want = (sel == rcrx_pkg::REG_FAILSAFE_TIMEOUT) ? cfg_failsafe_us : cfg_hop_us;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {sel, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== want)
            report_mismatch($sformatf("register %0d read %0h expected %0h", sel, prdata, want));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic sel, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (sel == rcrx_pkg::REG_FAILSAFE_TIMEOUT) cfg_failsafe_us = value;
        else cfg_hop_us = value;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        check_reg(sel);
    endtask

    // One packet of random shape: data, bad header, stray bind, or a few polls
    task automatic send_random_packet();
        logic [7:0] pkt [24];
        int unsigned pick, len, w, kind;
        kind = $urandom_range(0, 99);
        if (kind >= 90) begin
            repeat ($urandom_range(1, 5)) begin
                tick_stamp();
                send_word(rcrx_pkg::ACTION_POLL, 8'($urandom), 1'($urandom), stamp_us);
            end
            return;
        end
        foreach (pkt[i]) pkt[i] = 8'($urandom);
        pkt[0] = (kind < 70) ? rcrx_pkg::DATA_MARK :
                 (kind < 80) ? 8'($urandom) : rcrx_pkg::BIND_MARK;
        for (int p = 9; p <= 15; p += 2) begin
            pick = $urandom_range(0, 9);
            w = (pick < 4) ? $urandom_range(0, 3000) :
                (pick < 7) ? $urandom_range(900, 2100) : $urandom_range(0, 65535);
            pkt[p] = w[7:0];
            pkt[p + 1] = w[15:8];
        end
        pick = $urandom_range(0, 99);
        len = (pick < 75) ? PKT_LEN :
              (pick < 90) ? $urandom_range(1, PKT_LEN - 1) : $urandom_range(PKT_LEN + 1, 24);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                tick_stamp();
                send_word(rcrx_pkg::ACTION_POLL, 8'($urandom), 1'($urandom), stamp_us);
            end
            tick_stamp();
            send_word(rcrx_pkg::ACTION_BYTE, pkt[i], i == len - 1, stamp_us);
        end
    endtask

    task automatic test_register_reset();
        check_reg(rcrx_pkg::REG_FAILSAFE_TIMEOUT);
        check_reg(rcrx_pkg::REG_HOP_TIMEOUT);
    endtask

    // Poll with a last mark, a packet with a bad header, then failsafe before any bind
    task automatic test_unbound();
        send_word(rcrx_pkg::ACTION_POLL, 8'hFF, 1'b1, 32'd100);
        send_word(rcrx_pkg::ACTION_BYTE, 8'h12, 1'b0, 32'd200);
        send_word(rcrx_pkg::ACTION_BYTE, 8'h34, 1'b1, 32'd300);
        stamp_us = 32'd1_500_000;
        send_word(rcrx_pkg::ACTION_POLL, 8'h00, 1'b0, stamp_us);
    endtask

    // Bind long after reset: the stale packet stamp adds a second hop
    task automatic test_bind_late_hop();
        send_word(rcrx_pkg::ACTION_BYTE, rcrx_pkg::BIND_MARK, 1'b0, stamp_us + 10);
        send_word(rcrx_pkg::ACTION_BYTE, 8'hFF, 1'b0, stamp_us + 20);
        send_word(rcrx_pkg::ACTION_BYTE, 8'hFF, 1'b1, stamp_us + 30);
        stamp_us += 30;
    endtask

    // Full-scale sticks and both aux bits, then a one-byte packet reusing stale bytes
    task automatic test_stick_extremes();
        for (int i = 0; i < PKT_LEN; i++) begin
            stamp_us += 10;
            send_word(rcrx_pkg::ACTION_BYTE, (i == 0) ? rcrx_pkg::DATA_MARK : 8'hFF,
                      i == PKT_LEN - 1, stamp_us);
        end
        stamp_us += 10;
        send_word(rcrx_pkg::ACTION_BYTE, rcrx_pkg::DATA_MARK, 1'b1, stamp_us);
    endtask

    task automatic test_random_traffic(input logic [31:0] fs_us, input logic [31:0] hop_us,
                                       input int n_items);
        int target;
        wait_drained();
        write_reg(rcrx_pkg::REG_FAILSAFE_TIMEOUT, fs_us);
        write_reg(rcrx_pkg::REG_HOP_TIMEOUT, hop_us);
        target = items_sent + n_items;
        while (items_sent < target) send_random_packet();
    endtask

    // Long receiver hold against back-to-back input, then a full drain before more traffic
    task automatic test_output_stall();
        int target;
        sink_hold_cycles = 300;
        src_no_gaps = 1'b1;
        target = items_sent + 60;
        while (items_sent < target) send_random_packet();
        src_no_gaps = 1'b0;
        wait_drained();
        target = items_sent + 40;
        while (items_sent < target) send_random_packet();
    endtask

    task automatic test_time_wrap();
        int target;
        stamp_us = 32'hFFFF_F000;
        target = items_sent + 60;
        while (items_sent < target) send_random_packet();
    endtask

    initial begin : result_sink
        int stall, run_left;
        run_left = 0;
        forever begin
            if (sink_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (sink_hold_cycles) @(posedge i_clk);
                sink_hold_cycles = 0;
            end
            stall = draw_wait(run_left);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_rc_result got, want;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (rc_expected.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                got = m_axis_tdata[58:0];
                want = rc_expected.pop_front();
                check_field("roll_cmd", got.roll, want.roll);
                check_field("pitch_cmd", got.pitch, want.pitch);
                check_field("yaw_cmd", got.yaw, want.yaw);
                check_field("throttle_cmd", got.throttle, want.throttle);
                check_field("aux_arm", got.aux_arm, want.aux_arm);
                check_field("aux_rates", got.aux_rates, want.aux_rates);
                check_field("aux_changed", got.aux_changed, want.aux_changed);
                check_field("failsafe_active", got.failsafe, want.failsafe);
                check_field("bound", got.bound, want.bound);
                check_field("rf_channel", got.rf_channel, want.rf_channel);
                check_field("packet_valid", got.packet_valid, want.packet_valid);
                check_field("pad bits", m_axis_tdata[63:59], '0);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_reset();
        test_unbound();
        test_bind_late_hop();
        test_stick_extremes();
        test_random_traffic(rcrx_pkg::FAILSAFE_TIMEOUT_RST, rcrx_pkg::HOP_TIMEOUT_RST, 170);
        test_random_traffic(32'd0, 32'd0, 120);
        test_random_traffic(32'hFFFF_FFFF, 32'hFFFF_FFFF, 120);
        test_random_traffic($urandom_range(20000, 200000), $urandom_range(500, 10000), 150);
        test_random_traffic(rcrx_pkg::FAILSAFE_TIMEOUT_RST, rcrx_pkg::HOP_TIMEOUT_RST, 50);
        test_output_stall();
        test_time_wrap();
        wait_drained();
        repeat (5) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/rcrx_pkg.sv
sv/rcrx_packet_decode.sv
sv/rc_receiver_bind_hop_failsafe_core.sv
bench/rc_receiver_bind_hop_failsafe_core_tb.sv
